// ----- rtl/core/crc_pkg.sv -----
// Package for the Chinese remainder combiner: sizes and the sequencer states.
// Used by every module of the block except crc_ram; it depends on nothing else.
`default_nettype none
package crc_pkg;

	localparam int MAX_PAIRS = 8;
	localparam int IDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
	localparam int VAL_W     = 8;
	localparam int WIDE_W    = 64;
	localparam int PAIR_W    = 2 * VAL_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_P_RD,
		S_P_MUL,
		S_O_RD,
		S_O_GET,
		S_X_RD,
		S_X_MUL,
		S_M1_GO,
		S_MOD1,
		S_EUC,
		S_M2_GO,
		S_MOD2,
		S_TERM,
		S_ACC,
		S_NEXT,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/core/crc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none
module crc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire                                         clk,
	input  wire                                         we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                             wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/crc_modred.sv -----
// Bit-serial reduction of a 64-bit value modulo an 8-bit modulus, one bit a cycle.
// Depends on crc_pkg for the widths.
`default_nettype none
module crc_modred (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire [crc_pkg::WIDE_W-1:0]  value,
	input  wire [crc_pkg::VAL_W-1:0]   modulus,
	output logic [crc_pkg::VAL_W-1:0]  remainder,
	output logic                       done
);
	import crc_pkg::*;

	logic [WIDE_W-1:0]         val_q;
	logic [VAL_W-1:0]          m_q;
	logic [$clog2(WIDE_W)-1:0] cnt_q;
	logic                      busy_q;
	logic [VAL_W:0]            trial;
	logic [VAL_W:0]            reduced;

	always_comb begin
		trial   = {remainder, val_q[WIDE_W-1]};
		reduced = (trial >= {1'b0, m_q}) ? (trial - {1'b0, m_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q     <= value;
			m_q       <= modulus;
			remainder <= '0;
		end else if (busy_q) begin
			val_q     <= {val_q[WIDE_W-2:0], 1'b0};
			remainder <= reduced[VAL_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/crc_euclid.sv -----
// Extended Euclid by repeated subtraction: one subtract or swap a cycle.
// Gives the inverse of c modulo m, or zero when they are not coprime. Uses crc_pkg.
`default_nettype none
module crc_euclid (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [crc_pkg::VAL_W-1:0]  c,
	input  wire [crc_pkg::VAL_W-1:0]  m,
	output logic [crc_pkg::VAL_W-1:0] inverse,
	output logic                      done
);
	import crc_pkg::*;

	logic [VAL_W-1:0]        r0_q, r1_q, m_q;
	logic signed [VAL_W+1:0] t0_q, t1_q;
	logic signed [VAL_W+1:0] m_s;
	logic signed [VAL_W+1:0] t_norm;
	logic                    busy_q;

	always_comb begin
		m_s = $signed({2'b00, m_q});
		if (t0_q < 0) begin
			t_norm = t0_q + m_s;
		end else if (t0_q >= m_s) begin
			t_norm = t0_q - m_s;
		end else begin
			t_norm = t0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done   <= 1'b0;
		end else if (busy_q && r1_q == '0) begin
			busy_q <= 1'b0;
			done   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r0_q <= m;
			r1_q <= c;
			m_q  <= m;
			t0_q <= '0;
			t1_q <= (VAL_W+2)'(1);
		end else if (busy_q) begin
			if (r1_q == '0) begin
				inverse <= (r0_q == VAL_W'(1)) ? t_norm[VAL_W-1:0] : '0;
			end else if (r0_q >= r1_q) begin
				// One unit of the quotient at a time.
				r0_q <= r0_q - r1_q;
				t0_q <= t0_q - t1_q;
			end else begin
				r0_q <= r1_q;
				r1_q <= r0_q;
				t0_q <= t1_q;
				t1_q <= t0_q;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/chinese_remainder_combiner_unit.sv -----
// Top level of the Chinese remainder combiner: pair RAM, sequencer and datapath.
// Depends on crc_pkg, crc_ram, crc_modred and crc_euclid.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid in_ready residue modulus last_pair | in
//   output  | out_valid out_ready solution modulus_product | out
//
// A pair is taken whenever in_valid and in_ready are both high. The marked last
// pair starts the combination of N stored pairs: first the product of all moduli
// is built, then per pair the pair is read, the other moduli are multiplied, two
// serial reductions run through all 64 bits of their value around one Euclid run
// of one subtraction or swap at a time, and the term is accumulated.
// Reset clears the sequencer, pair count and output valid; the RAM is not cleared.
// Pairs are accepted while a result waits at the output; a finished result
// holds the sequencer until the output register is free.
`default_nettype none
module chinese_remainder_combiner_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [crc_pkg::VAL_W-1:0]   residue,
	input  wire [crc_pkg::VAL_W-1:0]   modulus,
	input  wire                        last_pair,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [crc_pkg::WIDE_W-1:0] solution,
	output logic [crc_pkg::WIDE_W-1:0] modulus_product
);
	import crc_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, n_q, cnt_next;
	logic [IDX_W-1:0]   i_q, j_q, raddr;
	logic [WIDE_W-1:0]  big_q, sum_q, part_q, term_q, room;
	logic [VAL_W-1:0]   mi_q, ri_q, k_q;
	logic               accept, store;
	logic [VAL_W-1:0]   mod_fix;
	logic [PAIR_W-1:0]  rdata;
	logic [VAL_W-1:0]   rd_mod;
	logic [WIDE_W+VAL_W-1:0] big_mul, part_mul, term_mul;
	logic [2*VAL_W-1:0] rk_mul;
	logic               j_end, i_end;
	logic               md_start, md_done, eu_start, eu_done;
	logic [WIDE_W-1:0]  md_value;
	logic [VAL_W-1:0]   md_rem, eu_inv;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign store    = accept && (cnt_q < CNT_W'(MAX_PAIRS));
	assign mod_fix  = (modulus == '0) ? VAL_W'(1) : modulus;
	assign cnt_next = store ? (cnt_q + CNT_W'(1)) : cnt_q;
	assign rd_mod   = rdata[VAL_W-1:0];
	assign j_end    = (CNT_W'(j_q) == n_q - CNT_W'(1));
	assign i_end    = (CNT_W'(i_q) == n_q - CNT_W'(1));
	assign big_mul  = big_q * rd_mod;
	assign part_mul = part_q * rd_mod;
	assign term_mul = part_q * k_q;
	assign rk_mul   = ri_q * eu_inv;
	assign room     = big_q - term_q;
	assign md_value = (state_q == S_M2_GO) ? WIDE_W'(rk_mul) : part_q;

	crc_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(MAX_PAIRS)
	) u_pair_ram (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({residue, mod_fix}),
		.raddr (raddr),
		.rdata (rdata)
	);

	crc_modred u_modred (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (md_start),
		.value     (md_value),
		.modulus   (mi_q),
		.remainder (md_rem),
		.done      (md_done)
	);

	crc_euclid u_euclid (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (eu_start),
		.c       (md_rem),
		.m       (mi_q),
		.inverse (eu_inv),
		.done    (eu_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		raddr    = j_q;
		md_start = 1'b0;
		eu_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && last_pair) begin
					state_d = (cnt_next == '0) ? S_DONE : S_P_RD;
				end
			end
			S_P_RD:  state_d = S_P_MUL;
			S_P_MUL: state_d = j_end ? S_O_RD : S_P_RD;
			S_O_RD: begin
				raddr   = i_q;
				state_d = S_O_GET;
			end
			S_O_GET: state_d = (rd_mod < VAL_W'(2)) ? S_NEXT : S_X_RD;
			S_X_RD:  state_d = S_X_MUL;
			S_X_MUL: state_d = j_end ? S_M1_GO : S_X_RD;
			S_M1_GO: begin
				md_start = 1'b1;
				state_d  = S_MOD1;
			end
			S_MOD1: begin
				if (md_done) begin
					eu_start = 1'b1;
					state_d  = S_EUC;
				end
			end
			S_EUC:   state_d = eu_done ? S_M2_GO : S_EUC;
			S_M2_GO: begin
				md_start = 1'b1;
				state_d  = S_MOD2;
			end
			S_MOD2:  state_d = md_done ? S_TERM : S_MOD2;
			S_TERM:  state_d = S_ACC;
			S_ACC:   state_d = S_NEXT;
			S_NEXT:  state_d = i_end ? S_DONE : S_O_RD;
			S_DONE:  state_d = out_valid ? S_DONE : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= last_pair ? '0 : cnt_next;
			end
			if (state_q == S_DONE && !out_valid) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= cnt_next;
				big_q <= WIDE_W'(1);
				sum_q <= '0;
				i_q   <= '0;
				j_q   <= '0;
			end
			S_P_MUL: begin
				big_q <= big_mul[WIDE_W-1:0];
				j_q   <= j_end ? '0 : (j_q + IDX_W'(1));
			end
			S_O_GET: begin
				ri_q   <= rdata[PAIR_W-1:VAL_W];
				mi_q   <= rd_mod;
				part_q <= WIDE_W'(1);
				j_q    <= '0;
			end
			S_X_MUL: begin
				// The product of all other moduli is big / m without a divider.
				if (j_q != i_q) begin
					part_q <= part_mul[WIDE_W-1:0];
				end
				j_q <= j_end ? '0 : (j_q + IDX_W'(1));
			end
			S_MOD2:  k_q    <= md_rem;
			S_TERM:  term_q <= term_mul[WIDE_W-1:0];
			S_ACC:   sum_q  <= (sum_q >= room) ? (sum_q - room) : (sum_q + term_q);
			S_NEXT:  i_q    <= i_q + IDX_W'(1);
			S_DONE: begin
				if (!out_valid) begin
					solution        <= sum_q;
					modulus_product <= big_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
